@@ hdl/cobt_pkg.sv @@
// ----------------------------------------------------------------------------
// cobt_pkg: shared types, constants and the quarter-wave sine table
// Holds the pipeline control struct and the sine helpers for the
// circle versus rotated box test.
// ----------------------------------------------------------------------------
`default_nettype none

package cobt_pkg;

   localparam int NUM_STAGES = 7;
   localparam int SINE_BITS  = 16;     // signed Q1.14 sine and cosine
   localparam int TAB_BITS   = 15;     // unsigned table entry, 0..16384
   localparam int DELTA_BITS = 9;      // step between neighboring entries
   localparam int FRAC_BITS  = 9;      // in-segment position, 0..256
   localparam int QUARTER    = 16384;  // quarter wave in table phase units
   localparam int ROT_SHIFT  = 14;
   localparam int ROT_ROUND  = 8192;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   typedef struct packed {
      logic [TAB_BITS-1:0]   base;
      logic [DELTA_BITS-1:0] delta;
      logic [FRAC_BITS-1:0]  frac;
      logic                  neg;
   } sine_prep_type;

   // round(16384 * sin(k * pi / 128)) for k = 0..64
   function automatic logic [TAB_BITS-1:0] sine_table(input logic [6:0] idx);
      logic [TAB_BITS-1:0] t;
      case (idx)
         7'd0:  t = 15'd0;      7'd1:  t = 15'd402;    7'd2:  t = 15'd804;
         7'd3:  t = 15'd1205;   7'd4:  t = 15'd1606;   7'd5:  t = 15'd2006;
         7'd6:  t = 15'd2404;   7'd7:  t = 15'd2801;   7'd8:  t = 15'd3196;
         7'd9:  t = 15'd3590;   7'd10: t = 15'd3981;   7'd11: t = 15'd4370;
         7'd12: t = 15'd4756;   7'd13: t = 15'd5139;   7'd14: t = 15'd5520;
         7'd15: t = 15'd5897;   7'd16: t = 15'd6270;   7'd17: t = 15'd6639;
         7'd18: t = 15'd7005;   7'd19: t = 15'd7366;   7'd20: t = 15'd7723;
         7'd21: t = 15'd8076;   7'd22: t = 15'd8423;   7'd23: t = 15'd8765;
         7'd24: t = 15'd9102;   7'd25: t = 15'd9434;   7'd26: t = 15'd9760;
         7'd27: t = 15'd10080;  7'd28: t = 15'd10394;  7'd29: t = 15'd10702;
         7'd30: t = 15'd11003;  7'd31: t = 15'd11297;  7'd32: t = 15'd11585;
         7'd33: t = 15'd11866;  7'd34: t = 15'd12140;  7'd35: t = 15'd12406;
         7'd36: t = 15'd12665;  7'd37: t = 15'd12916;  7'd38: t = 15'd13160;
         7'd39: t = 15'd13395;  7'd40: t = 15'd13623;  7'd41: t = 15'd13842;
         7'd42: t = 15'd14053;  7'd43: t = 15'd14256;  7'd44: t = 15'd14449;
         7'd45: t = 15'd14635;  7'd46: t = 15'd14811;  7'd47: t = 15'd14978;
         7'd48: t = 15'd15137;  7'd49: t = 15'd15286;  7'd50: t = 15'd15426;
         7'd51: t = 15'd15557;  7'd52: t = 15'd15679;  7'd53: t = 15'd15791;
         7'd54: t = 15'd15893;  7'd55: t = 15'd15986;  7'd56: t = 15'd16069;
         7'd57: t = 15'd16143;  7'd58: t = 15'd16207;  7'd59: t = 15'd16261;
         7'd60: t = 15'd16305;  7'd61: t = 15'd16340;  7'd62: t = 15'd16364;
         7'd63: t = 15'd16379;  7'd64: t = 15'd16384;
         default: t = 15'd16384;
      endcase
      return t;
   endfunction

   // Folds the quadrant, splits the phase into segment and fraction and
   // fetches the two table entries around it.
   function automatic sine_prep_type sine_prep(input logic [1:0] quad,
                                               input logic [13:0] phase);
      logic [TAB_BITS-1:0] v;
      logic [5:0]          seg;
      logic [TAB_BITS-1:0] lo;
      logic [TAB_BITS-1:0] hi;
      sine_prep_type       p;
      v = quad[0] ? (15'(QUARTER) - {1'b0, phase}) : {1'b0, phase};
      if (v[14]) begin
         seg    = 6'd63;
         p.frac = 9'd256;
      end else begin
         seg    = v[13:8];
         p.frac = {1'b0, v[7:0]};
      end
      lo      = sine_table({1'b0, seg});
      hi      = sine_table({1'b0, seg} + 7'd1);
      p.base  = lo;
      p.delta = DELTA_BITS'(hi - lo);
      p.neg   = quad[1];
      return p;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cobt_sincos.sv @@
// ----------------------------------------------------------------------------
// cobt_sincos: sine and cosine of the box angle
// Two stages: table fetch, then linear interpolation and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module cobt_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire cobt_pkg::pipe_ctl_type                 ctl,
   input  wire logic [ANGLE_BITS-1:0]                  angle,
   output logic signed [cobt_pkg::SINE_BITS-1:0]       sine,
   output logic signed [cobt_pkg::SINE_BITS-1:0]       cosine
);

   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   logic [ANGLE_BITS-1:0]   cos_angle;
   logic [13:0]             sin_phase;
   logic [13:0]             cos_phase;
   cobt_pkg::sine_prep_type sin_prep_ff, sin_prep_in;
   cobt_pkg::sine_prep_type cos_prep_ff, cos_prep_in;
   logic signed [cobt_pkg::SINE_BITS-1:0] sine_ff, cosine_ff;

   function automatic logic signed [cobt_pkg::SINE_BITS-1:0] interp(
      input cobt_pkg::sine_prep_type p);
      logic [17:0]                   prod;
      logic [cobt_pkg::TAB_BITS-1:0] mag;
      prod = 18'(p.delta) * 18'(p.frac) + 18'd128;
      mag  = p.base + cobt_pkg::TAB_BITS'(prod >> 8);
      return p.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   assign cos_angle   = angle + QUARTER_TURN;
   assign sin_phase   = 14'(angle[ANGLE_BITS-3:0]) << (16 - ANGLE_BITS);
   assign cos_phase   = 14'(cos_angle[ANGLE_BITS-3:0]) << (16 - ANGLE_BITS);
   assign sin_prep_in = cobt_pkg::sine_prep(angle[ANGLE_BITS-1 -: 2], sin_phase);
   assign cos_prep_in = cobt_pkg::sine_prep(cos_angle[ANGLE_BITS-1 -: 2], cos_phase);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         sin_prep_ff <= sin_prep_in;
         cos_prep_ff <= cos_prep_in;
      end
      if (ctl.load[1]) begin
         sine_ff   <= interp(sin_prep_ff);
         cosine_ff <= interp(cos_prep_ff);
      end
   end

   assign sine   = sine_ff;
   assign cosine = cosine_ff;

endmodule

`default_nettype wire

@@ hdl/cobt_rotate.sv @@
// ----------------------------------------------------------------------------
// cobt_rotate: circle center into the box frame
// Center difference, four products, then rounded sums scaled back to Q.8.
// ----------------------------------------------------------------------------
`default_nettype none

module cobt_rotate #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                                    clock,
   input  wire cobt_pkg::pipe_ctl_type                  ctl,
   input  wire logic signed [COORD_BITS-1:0]            box_center_x,
   input  wire logic signed [COORD_BITS-1:0]            box_center_y,
   input  wire logic signed [COORD_BITS-1:0]            circle_center_x,
   input  wire logic signed [COORD_BITS-1:0]            circle_center_y,
   input  wire logic signed [cobt_pkg::SINE_BITS-1:0]   sine,
   input  wire logic signed [cobt_pkg::SINE_BITS-1:0]   cosine,
   output logic signed [COORD_BITS+3:0]                 local_x,
   output logic signed [COORD_BITS+3:0]                 local_y
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = DW + cobt_pkg::SINE_BITS;
   localparam int SW = PW + 1;

   logic signed [DW-1:0] dx_ff, dy_ff, dx2_ff, dy2_ff;
   logic signed [PW-1:0] cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   logic signed [SW-1:0] sum_x_in, sum_y_in;
   logic signed [COORD_BITS+3:0] local_x_ff, local_y_ff;

   assign sum_x_in = SW'(cdx_ff) + SW'(sdy_ff) + SW'(cobt_pkg::ROT_ROUND);
   assign sum_y_in = SW'(cdy_ff) - SW'(sdx_ff) + SW'(cobt_pkg::ROT_ROUND);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         dx_ff <= DW'(circle_center_x) - DW'(box_center_x);
         dy_ff <= DW'(circle_center_y) - DW'(box_center_y);
      end
      if (ctl.load[1]) begin
         dx2_ff <= dx_ff;
         dy2_ff <= dy_ff;
      end
      if (ctl.load[2]) begin
         cdx_ff <= PW'(cosine) * PW'(dx2_ff);
         sdy_ff <= PW'(sine) * PW'(dy2_ff);
         cdy_ff <= PW'(cosine) * PW'(dy2_ff);
         sdx_ff <= PW'(sine) * PW'(dx2_ff);
      end
      // An arithmetic shift of the rounded sum is the floor division.
      if (ctl.load[3]) begin
         local_x_ff <= sum_x_in[SW-1:cobt_pkg::ROT_SHIFT];
         local_y_ff <= sum_y_in[SW-1:cobt_pkg::ROT_SHIFT];
      end
   end

   assign local_x = local_x_ff;
   assign local_y = local_y_ff;

endmodule

`default_nettype wire

@@ hdl/cobt_clamp_cmp.sv @@
// ----------------------------------------------------------------------------
// cobt_clamp_cmp: distance outside the box and the radius compare
// Excess per axis, squares, then the strict compare against the radius.
// ----------------------------------------------------------------------------
`default_nettype none

module cobt_clamp_cmp #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                        clock,
   input  wire cobt_pkg::pipe_ctl_type      ctl,
   input  wire logic [COORD_BITS-2:0]       box_width,
   input  wire logic [COORD_BITS-2:0]       box_height,
   input  wire logic [COORD_BITS-2:0]       circle_radius,
   input  wire logic signed [COORD_BITS+3:0] local_x,
   input  wire logic signed [COORD_BITS+3:0] local_y,
   output logic                             hit
);

   localparam int LW = COORD_BITS + 4;
   localparam int EW = COORD_BITS + 1;
   localparam int QW = 2 * EW;

   logic [COORD_BITS-2:0] w_ff [4];
   logic [COORD_BITS-2:0] h_ff [4];
   logic [COORD_BITS-2:0] r_ff [5];
   logic [EW-1:0]         ex_ff, ey_ff;
   logic [QW-1:0]         sqx_ff, sqy_ff;
   logic [2*COORD_BITS-1:0] rsq_ff;
   logic [COORD_BITS-1:0] diam;
   logic [QW:0]           dist_in;
   logic                  hit_ff;

   // Excess of twice the coordinate over the full extent. Anything at or
   // above 2^COORD_BITS already exceeds every diameter, so it saturates there.
   function automatic logic [EW-1:0] excess(input logic signed [LW-1:0] l,
                                            input logic [COORD_BITS-2:0] full);
      logic [LW-1:0] mag;
      logic [LW:0]   twice;
      logic [LW:0]   diff;
      mag   = l[LW-1] ? LW'(-l) : LW'(l);
      twice = {mag, 1'b0};
      diff  = (twice > (LW+1)'(full)) ? (twice - (LW+1)'(full)) : '0;
      return (diff[LW:COORD_BITS] != '0) ? {1'b1, {COORD_BITS{1'b0}}} : diff[EW-1:0];
   endfunction

   assign diam    = {r_ff[4], 1'b0};
   assign dist_in = (QW+1)'(sqx_ff) + (QW+1)'(sqy_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         w_ff[0] <= box_width;
         h_ff[0] <= box_height;
         r_ff[0] <= circle_radius;
      end
      for (int k = 1; k < 4; k++) begin
         if (ctl.load[k]) begin
            w_ff[k] <= w_ff[k-1];
            h_ff[k] <= h_ff[k-1];
            r_ff[k] <= r_ff[k-1];
         end
      end
      if (ctl.load[4]) begin
         r_ff[4] <= r_ff[3];
         ex_ff   <= excess(local_x, w_ff[3]);
         ey_ff   <= excess(local_y, h_ff[3]);
      end
      if (ctl.load[5]) begin
         sqx_ff <= QW'(ex_ff) * QW'(ex_ff);
         sqy_ff <= QW'(ey_ff) * QW'(ey_ff);
         rsq_ff <= (2*COORD_BITS)'(diam) * (2*COORD_BITS)'(diam);
      end
      if (ctl.load[6]) begin
         hit_ff <= dist_in < (QW+1)'(rsq_ff);
      end
   end

   assign hit = hit_ff;

endmodule

`default_nettype wire

@@ hdl/circle_vs_rotated_box_test.sv @@
// ----------------------------------------------------------------------------
// circle_vs_rotated_box_test: circle versus oriented rectangle overlap test
// Seven-stage pipeline that tests one circle and rectangle pair per transfer.
// ----------------------------------------------------------------------------
// Each request transfer carries one test pair: the center, full width, full
// height and binary-angle rotation of a rectangle, and the center and radius
// of a circle, all coordinates in signed Q15.8 at the default width. The block
// moves the circle center into the rectangle's own frame by rotating it by
// minus the rectangle angle (sine and cosine come from an interpolated
// quarter-wave table in Q1.14), measures how far it lies outside the
// rectangle on each axis and reports a hit when the squared distance is
// strictly below the squared radius. A circle that only touches an edge, and
// a circle of zero radius, never hit. Every request gives exactly one
// response, in order. The pipeline has seven register stages: table fetch,
// interpolation, the four rotation products, the rounded rotation sums, the
// per-axis excess, the squares, and the final compare, which is the response
// register. One request is accepted every cycle as long as the response side
// keeps up. Each stage loads when it is empty or when the stage after it moves
// on, so a stalled response only stops the stages behind it that are full;
// bubbles further back still fill, and nothing is lost or sent twice. There
// is no configuration and no state carried between pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_vs_rotated_box_test #(
   parameter int COORD_BITS = 24,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // From bit 0 up: box_center_x, box_center_y, box_width, box_height,
   // box_angle, circle_center_x, circle_center_y, circle_radius, zero fill.
   input  wire logic [((7*COORD_BITS-3+ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // From bit 0 up: hit, zero fill.
   output logic [7:0]                rsp_tdata
);

   localparam int NS      = cobt_pkg::NUM_STAGES;
   localparam int BCX_LSB = 0;
   localparam int BCY_LSB = COORD_BITS;
   localparam int BW_LSB  = 2*COORD_BITS;
   localparam int BH_LSB  = 3*COORD_BITS - 1;
   localparam int ANG_LSB = 4*COORD_BITS - 2;
   localparam int CCX_LSB = 4*COORD_BITS - 2 + ANGLE_BITS;
   localparam int CCY_LSB = 5*COORD_BITS - 2 + ANGLE_BITS;
   localparam int RAD_LSB = 6*COORD_BITS - 2 + ANGLE_BITS;

   logic signed [COORD_BITS-1:0] box_center_x, box_center_y;
   logic signed [COORD_BITS-1:0] circle_center_x, circle_center_y;
   logic [COORD_BITS-2:0]        box_width, box_height, circle_radius;
   logic [ANGLE_BITS-1:0]        box_angle;

   logic [NS-1:0]                valid_ff, valid_in;
   logic [NS-1:0]                stage_ready;
   cobt_pkg::pipe_ctl_type       ctl;

   logic signed [cobt_pkg::SINE_BITS-1:0] sine, cosine;
   logic signed [COORD_BITS+3:0]          local_x, local_y;
   logic                                  hit;

   // Request fields.
   assign box_center_x    = req_tdata[BCX_LSB +: COORD_BITS];
   assign box_center_y    = req_tdata[BCY_LSB +: COORD_BITS];
   assign box_width       = req_tdata[BW_LSB  +: COORD_BITS-1];
   assign box_height      = req_tdata[BH_LSB  +: COORD_BITS-1];
   assign box_angle       = req_tdata[ANG_LSB +: ANGLE_BITS];
   assign circle_center_x = req_tdata[CCX_LSB +: COORD_BITS];
   assign circle_center_y = req_tdata[CCY_LSB +: COORD_BITS];
   assign circle_radius   = req_tdata[RAD_LSB +: COORD_BITS-1];

   // A stage may load when it is empty or when its content moves on this
   // cycle. The last stage moves on when the response transfer completes.
   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS-2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_comb begin
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign ctl.load = stage_ready;

   cobt_sincos #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_sincos (
      .clock  (clock),
      .ctl    (ctl),
      .angle  (box_angle),
      .sine   (sine),
      .cosine (cosine)
   );

   cobt_rotate #(
      .COORD_BITS (COORD_BITS)
   ) u_rotate (
      .clock           (clock),
      .ctl             (ctl),
      .box_center_x    (box_center_x),
      .box_center_y    (box_center_y),
      .circle_center_x (circle_center_x),
      .circle_center_y (circle_center_y),
      .sine            (sine),
      .cosine          (cosine),
      .local_x         (local_x),
      .local_y         (local_y)
   );

   cobt_clamp_cmp #(
      .COORD_BITS (COORD_BITS)
   ) u_clamp_cmp (
      .clock         (clock),
      .ctl           (ctl),
      .box_width     (box_width),
      .box_height    (box_height),
      .circle_radius (circle_radius),
      .local_x       (local_x),
      .local_y       (local_y),
      .hit           (hit)
   );

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {7'b0, hit};

`ifndef ASSERT_OFF
   // Any empty stage means the pipeline has room for a new request.
   a_room_accepts: assert property (@(posedge clock) disable iff (reset)
      (valid_ff != {NS{1'b1}}) |-> req_tready)
      else $error("request refused while a pipeline stage is empty");

   // A full pipeline behind a stalled response keeps every item.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff == {NS{1'b1}}) && !rsp_tready) |=> (valid_ff == {NS{1'b1}}))
      else $error("pipeline item dropped during a response stall");

   // An accepted request occupies the first stage on the next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted request did not enter the first stage");
`endif

endmodule

`default_nettype wire
